### design/lsg_pkg.sv
// Package for the load stage governor: mode, stage and reason codes and the
// flap guard limits. Has no dependencies; imported by load_stage_governor.
package lsg_pkg;

   // Mode register codes
   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_OFF    = 2'd1;
   localparam logic [1:0] MODE_FORCE1 = 2'd2;
   localparam logic [1:0] MODE_FORCE2 = 2'd3;

   // Throttle stages
   localparam logic [1:0] STAGE_0 = 2'd0;
   localparam logic [1:0] STAGE_1 = 2'd1;
   localparam logic [1:0] STAGE_2 = 2'd2;

   // Reason codes
   localparam logic [2:0] RSN_NONE      = 3'd0;
   localparam logic [2:0] RSN_INITIAL   = 3'd1;
   localparam logic [2:0] RSN_FORCED    = 3'd2;
   localparam logic [2:0] RSN_OFF       = 3'd3;
   localparam logic [2:0] RSN_OVER      = 3'd4;
   localparam logic [2:0] RSN_RECOVERED = 3'd5;
   localparam logic [2:0] RSN_FAILED    = 3'd6;

   // Request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FAILED = 1'b1;

   // Register indexes
   localparam logic [2:0] REG_MODE         = 3'd0;
   localparam logic [2:0] REG_OVER_MARGIN  = 3'd1;
   localparam logic [2:0] REG_UNDER_MARGIN = 3'd2;
   localparam logic [2:0] REG_MAX_OVER_DRN = 3'd3;
   localparam logic [2:0] REG_MIN_REC_DRN  = 3'd4;
   localparam logic [2:0] REG_ENGAGE       = 3'd5;
   localparam logic [2:0] REG_RESTORE      = 3'd6;
   localparam logic [2:0] REG_FLAP_WINDOW  = 3'd7;

   // Flap guard
   localparam logic [7:0] FLAP_LIMIT = 8'd2;
   localparam logic [7:0] TALLY_MAX  = 8'hFF;

endpackage

### design/load_stage_governor.sv
// Load stage governor: three-level throttle governor with streak counters,
// flap guard, forced modes and freeze on apply failure. Depends on lsg_pkg.
// A request is registered in the input register, then in the result register, from
// which its response is presented. Throughput: one request per cycle while rsp_ready
// keeps the result register free, set by the state update between the two registers.
// Reset: synchronous; registers to defaults, auto mode, stage 0; a mode write re-inits.
module load_stage_governor (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_underrun_count,
   input  logic [15:0] req_emu_time,
   input  logic [15:0] req_budget_time,
   input  logic        req_headroom_valid,
   input  logic [15:0] req_drain_time,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_changed,
   output logic [1:0]  rsp_stage_now,
   output logic [2:0]  rsp_reason_code,
   output logic        rsp_held_flag,
   output logic        rsp_frozen_flag,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import lsg_pkg::*;

   // Configuration registers
   logic [1:0]  mode_ff;
   logic [15:0] over_margin_ff, under_margin_ff, max_over_drain_ff, min_rec_drain_ff;
   logic [15:0] engage_frames_ff, restore_frames_ff, flap_window_ff;

   // Input register
   logic        in_valid_ff;
   logic        in_op_ff;
   logic [15:0] in_underruns_ff, in_emu_ff, in_budget_ff, in_drain_ff;
   logic        in_hv_ff;

   // Governor state
   logic [1:0]  stage_ff, stage_in;
   logic [15:0] over_streak_ff, over_streak_in;
   logic [15:0] under_streak_ff, under_streak_in;
   logic [7:0]  tally_ff, tally_in;
   logic [15:0] since_engage_ff, since_engage_in;
   logic        hold_ff, hold_in;
   logic        failed_ff, failed_in;
   logic [2:0]  reason_ff, reason_in;
   logic        changed_in;

   // Result register
   logic        out_valid_ff;
   logic        out_changed_ff;
   logic [1:0]  out_stage_ff;
   logic [2:0]  out_reason_ff;
   logic        out_held_ff, out_frozen_ff;

   logic        advance, process, csr_write, mode_write;
   logic        over, recovered;
   logic [16:0] over_limit, rec_sum, over_sum, under_sum;
   logic [1:0]  init_mode, init_stage;

   // Handshake: result register frees when empty or taken
   assign advance   = !out_valid_ff || rsp_ready;
   assign process   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign mode_write = csr_write && (csr_index == REG_MODE);

   // Classify the frame sample
   assign over_limit = {1'b0, in_budget_ff} + {1'b0, over_margin_ff};
   assign rec_sum    = {1'b0, in_emu_ff} + {1'b0, under_margin_ff};
   assign over = (in_underruns_ff != 16'd0) || ({1'b0, in_emu_ff} > over_limit) ||
                 (in_hv_ff && (in_drain_ff <= max_over_drain_ff));
   assign recovered = (in_underruns_ff == 16'd0) && (rec_sum < {1'b0, in_budget_ff}) &&
                      (!in_hv_ff || (in_drain_ff >= min_rec_drain_ff));
   assign over_sum  = {1'b0, over_streak_ff} + 17'd1;
   assign under_sum = {1'b0, under_streak_ff} + 17'd1;

   // Next governor state for the request in the input register
   always_comb begin
      stage_in        = stage_ff;
      over_streak_in  = over_streak_ff;
      under_streak_in = under_streak_ff;
      tally_in        = tally_ff;
      since_engage_in = since_engage_ff;
      hold_in         = hold_ff;
      failed_in       = failed_ff;
      reason_in       = reason_ff;
      changed_in      = 1'b0;
      if (in_op_ff == OP_FAILED) begin
         failed_in       = 1'b1;
         over_streak_in  = 16'd0;
         under_streak_in = 16'd0;
         reason_in       = RSN_FAILED;
      end else if (!failed_ff) begin
         if (mode_ff == MODE_OFF) begin
            changed_in      = (stage_ff != STAGE_0);
            stage_in        = STAGE_0;
            over_streak_in  = 16'd0;
            under_streak_in = 16'd0;
            tally_in        = 8'd0;
            since_engage_in = 16'd0;
            hold_in         = 1'b0;
            if (changed_in) reason_in = RSN_OFF;
         end else if (mode_ff == MODE_FORCE1 || mode_ff == MODE_FORCE2) begin
            stage_in        = (mode_ff == MODE_FORCE1) ? STAGE_1 : STAGE_2;
            changed_in      = (stage_ff != stage_in);
            over_streak_in  = 16'd0;
            under_streak_in = 16'd0;
            if (changed_in) reason_in = RSN_FORCED;
         end else begin
            // decay the flap guard while below stage 2
            if (tally_ff != 8'd0 && stage_ff != STAGE_2) begin
               since_engage_in = since_engage_ff + 16'd1;
               if (since_engage_in >= flap_window_ff) begin
                  tally_in        = 8'd0;
                  since_engage_in = 16'd0;
                  hold_in         = 1'b0;
               end
            end
            // step the streaks
            if (over) begin
               over_streak_in  = (over_sum < {1'b0, engage_frames_ff}) ?
                                 over_sum[15:0] : engage_frames_ff;
               under_streak_in = 16'd0;
            end else if (recovered) begin
               under_streak_in = (under_sum < {1'b0, restore_frames_ff}) ?
                                 under_sum[15:0] : restore_frames_ff;
               over_streak_in  = 16'd0;
            end else begin
               over_streak_in  = 16'd0;
               under_streak_in = 16'd0;
            end
            // raise or lower the stage
            if (over && over_streak_in >= engage_frames_ff && stage_ff != STAGE_2) begin
               stage_in       = stage_ff + 2'd1;
               over_streak_in = 16'd0;
               reason_in      = RSN_OVER;
               changed_in     = 1'b1;
               if (stage_in == STAGE_2) begin
                  if (tally_in != TALLY_MAX) tally_in = tally_in + 8'd1;
                  since_engage_in = 16'd0;
                  if (tally_in >= FLAP_LIMIT) hold_in = 1'b1;
               end
            end else if (recovered && under_streak_in >= restore_frames_ff &&
                         stage_ff != STAGE_0 && !(stage_ff == STAGE_2 && hold_ff)) begin
               stage_in        = stage_ff - 2'd1;
               under_streak_in = 16'd0;
               reason_in       = RSN_RECOVERED;
               changed_in      = 1'b1;
            end
         end
      end
   end

   // Initial state on reset or mode write
   assign init_mode  = reset ? MODE_AUTO : csr_data[1:0];
   assign init_stage = (init_mode == MODE_FORCE1) ? STAGE_1 :
                       (init_mode == MODE_FORCE2) ? STAGE_2 : STAGE_0;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_AUTO;
         over_margin_ff    <= 16'd256;
         under_margin_ff   <= 16'd256;
         max_over_drain_ff <= 16'd128;
         min_rec_drain_ff  <= 16'd512;
         engage_frames_ff  <= 16'd30;
         restore_frames_ff <= 16'd120;
         flap_window_ff    <= 16'd600;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MODE:         mode_ff           <= csr_data[1:0];
            REG_OVER_MARGIN:  over_margin_ff    <= csr_data;
            REG_UNDER_MARGIN: under_margin_ff   <= csr_data;
            REG_MAX_OVER_DRN: max_over_drain_ff <= csr_data;
            REG_MIN_REC_DRN:  min_rec_drain_ff  <= csr_data;
            REG_ENGAGE:       engage_frames_ff  <= csr_data;
            REG_RESTORE:      restore_frames_ff <= csr_data;
            REG_FLAP_WINDOW:  flap_window_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Re-initialize or advance the governor state
   always_ff @(posedge clock) begin
      if (reset || mode_write) begin
         stage_ff        <= init_stage;
         over_streak_ff  <= 16'd0;
         under_streak_ff <= 16'd0;
         tally_ff        <= 8'd0;
         since_engage_ff <= 16'd0;
         hold_ff         <= 1'b0;
         failed_ff       <= 1'b0;
         reason_ff       <= (init_stage != STAGE_0) ? RSN_INITIAL : RSN_NONE;
      end else if (process) begin
         stage_ff        <= stage_in;
         over_streak_ff  <= over_streak_in;
         under_streak_ff <= under_streak_in;
         tally_ff        <= tally_in;
         since_engage_ff <= since_engage_in;
         hold_ff         <= hold_in;
         failed_ff       <= failed_in;
         reason_ff       <= reason_in;
      end
   end

   // Capture the request into the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_op_ff        <= req_op;
         in_underruns_ff <= req_underrun_count;
         in_emu_ff       <= req_emu_time;
         in_budget_ff    <= req_budget_time;
         in_hv_ff        <= req_headroom_valid;
         in_drain_ff     <= req_drain_time;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (process) begin
         out_changed_ff <= changed_in;
         out_stage_ff   <= stage_in;
         out_reason_ff  <= reason_in;
         out_held_ff    <= hold_in;
         out_frozen_ff  <= failed_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_changed     = out_changed_ff;
   assign rsp_stage_now   = out_stage_ff;
   assign rsp_reason_code = out_reason_ff;
   assign rsp_held_flag   = out_held_ff;
   assign rsp_frozen_flag = out_frozen_ff;

   // Freeze persists until reset or mode write
   a_frozen_sticky: assert property (@(posedge clock) disable iff (reset)
      (failed_ff && !mode_write) |=> failed_ff)
      else $error("governor left frozen state without re-init");

   // Flap guard hold only while at stage 2
   a_hold_stage2: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> (stage_ff == STAGE_2))
      else $error("hold set below stage 2");

   // A stage change always carries a reason
   a_change_reason: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_changed_ff) |-> (out_reason_ff != RSN_NONE))
      else $error("stage change without reason");

   // Stage stays in range
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff != 2'd3)
      else $error("stage out of range");

endmodule
